>>> src/multi_channel_tick_timer_macros.svh
// assertion macros shared by the timer bank rtl
// expects signals clk and arst_n in the module that uses them
`ifndef MULTI_CHANNEL_TICK_TIMER_MACROS_SVH
`define MULTI_CHANNEL_TICK_TIMER_MACROS_SVH

// same-cycle implication, off during reset
`define MCTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer bank check failed");

// next-cycle implication, off during reset
`define MCTT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer bank check failed");

`endif

>>> src/mctt_pkg.sv
// types and constants of the tick timer bank
// no dependencies
package mctt_pkg;

	localparam int FUNC_W    = 2;
	localparam int CHAN_ID_W = 4;
	localparam int PERIOD_W  = 16;
	localparam int MASK_W    = 8;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK      = 2'd0,
		FUNC_START_PER = 2'd1,
		FUNC_START_ONE = 2'd2,
		FUNC_STOP      = 2'd3
	} mctt_func_t;

	typedef struct packed {
		logic tick;
		logic load;
		logic one_shot;
		logic stop;
	} mctt_cmd_t;

endpackage

>>> src/mctt_chan.sv
// one timer channel: count, period, one-shot flag and run state
// depends on mctt_pkg
module mctt_chan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mctt_pkg::mctt_cmd_t             cmd,
	input  logic [mctt_pkg::PERIOD_W-1:0]   period,
	output logic                            fired
);
	import mctt_pkg::*;

	logic [PERIOD_W-1:0] count_q;
	logic [PERIOD_W-1:0] target_q;
	logic                one_shot_q;
	logic                active_q;
	logic [PERIOD_W:0]   next_cnt;
	logic                expire;

	assign next_cnt = {1'b0, count_q} + {{PERIOD_W{1'b0}}, 1'b1};
	assign expire   = next_cnt >= {1'b0, target_q};
	assign fired    = cmd.tick && active_q && expire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			target_q   <= '0;
			one_shot_q <= 1'b0;
			active_q   <= 1'b0;
		end else if (cmd.load) begin
			count_q    <= '0;
			target_q   <= period;
			one_shot_q <= cmd.one_shot;
			active_q   <= 1'b1;
		end else if (cmd.stop) begin
			active_q <= 1'b0;
		end else if (cmd.tick && active_q) begin
			if (expire) begin
				count_q <= '0;
				if (one_shot_q) begin
					active_q <= 1'b0;
				end
			end else begin
				count_q <= next_cnt[PERIOD_W-1:0];
			end
		end
	end

endmodule

>>> src/multi_channel_tick_timer.sv
// channel    | dir | tdata fields (low bit up)                     | tuser | tlast
// s_axis     | in  | func[1:0] chan_id[5:2] period[21:6], 0 pad    | -     | -
// m_axis     | out | status[0] fired_mask[8:1], 0 pad              | -     | -
// one request per cycle sustained while the result is not stalled; a request
// passes the input register and then the result register, channel state
// updates in the cycle a request leaves the input register
// reset clears all channel state and both handshake stages
// a stalled result holds the input register, which holds s_tready low
// top level of the tick timer bank; depends on mctt_pkg, mctt_chan and the macro header
`include "multi_channel_tick_timer_macros.svh"

module multi_channel_tick_timer #(
	parameter int CHANNELS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mctt_pkg::IN_W-1:0]   s_tdata,  // func, chan_id, period
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mctt_pkg::OUT_W-1:0]  m_tdata   // status, fired_mask
);
	import mctt_pkg::*;

	localparam logic [CHAN_ID_W:0] CHAN_LIMIT = (CHAN_ID_W+1)'(CHANNELS);

	logic                 valid_s1;
	mctt_func_t           func_s1;
	logic [CHAN_ID_W-1:0] chan_id_s1;
	logic [PERIOD_W-1:0]  period_s1;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic                 adv;
	logic                 bad_chan;
	logic                 err;
	logic                 is_start;
	logic [CHANNELS-1:0]  fired;
	logic [MASK_W-1:0]    mask;
	mctt_cmd_t            cmd [CHANNELS];

	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign is_start = (func_s1 == FUNC_START_PER) || (func_s1 == FUNC_START_ONE);
	assign bad_chan = {1'b0, chan_id_s1} >= CHAN_LIMIT;
	assign err      = (func_s1 != FUNC_TICK)
		&& (bad_chan || (is_start && (period_s1 == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1    <= mctt_func_t'(s_tdata[FUNC_W-1:0]);
			chan_id_s1 <= s_tdata[FUNC_W +: CHAN_ID_W];
			period_s1  <= s_tdata[FUNC_W+CHAN_ID_W +: PERIOD_W];
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CHANNELS; gi++) begin : g_chan
			logic hit;
			assign hit = adv && !err && (chan_id_s1 == CHAN_ID_W'(gi));
			assign cmd[gi].tick     = adv && (func_s1 == FUNC_TICK);
			assign cmd[gi].load     = hit && is_start;
			assign cmd[gi].one_shot = func_s1 == FUNC_START_ONE;
			assign cmd[gi].stop     = hit && (func_s1 == FUNC_STOP);

			mctt_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[gi]),
				.period (period_s1),
				.fired  (fired[gi])
			);
		end

		for (gi = 0; gi < MASK_W; gi++) begin : g_mask
			if (gi < CHANNELS) begin : g_bit
				assign mask[gi] = fired[gi];
			end else begin : g_zero
				assign mask[gi] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {{(OUT_W-MASK_W-1){1'b0}}, mask, err};
		end
	end

	// an error result never reports expiries
	`MCTT_ASSERT_IMP(a_err_no_mask, m_tvalid && m_tdata[0], m_tdata[MASK_W:1] == '0)
	// a request held by a stalled result stays in the input register
	`MCTT_ASSERT_NXT(a_hold_s1, valid_s1 && !adv, valid_s1)
	// an accepted request lands in the input register
	`MCTT_ASSERT_NXT(a_load_s1, s_tvalid && s_tready, valid_s1)
	// a request leaving the input register always yields a result
	`MCTT_ASSERT_NXT(a_adv_out, adv, m_tvalid)

endmodule

>>> tb/multi_channel_tick_timer_tb.sv
// self-checking bench for the tick timer bank: a directed pass over the corner cases,
// random command streams under several idle and stall mixes, and a long receiver hold
// depends on mctt_pkg and multi_channel_tick_timer
module multi_channel_tick_timer_tb;
	import mctt_pkg::*;

	localparam int CHANNELS = 8;
	localparam int IDX_W    = $clog2(CHANNELS);

	typedef struct packed {
		logic              status;
		logic [MASK_W-1:0] fired_mask;
	} timer_report_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;  // func, chan_id, period, zero pad
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;  // status, fired_mask, zero pad

	logic [PERIOD_W-1:0] chan_count [CHANNELS] = '{default: '0};
	logic [PERIOD_W-1:0] chan_period [CHANNELS] = '{default: '0};
	logic                chan_oneshot [CHANNELS] = '{default: 1'b0};
	logic                chan_running [CHANNELS] = '{default: 1'b0};

	timer_report_t       reports_due[$];
	int                  mismatches = 0;
	int                  tx_idle_pct = 0;
	int                  rx_stall_pct = 0;
	logic                rx_hold = 1'b0;

	multi_channel_tick_timer #(.CHANNELS(CHANNELS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic timer_report_t timer_bank_step(mctt_func_t func, logic [CHAN_ID_W-1:0] chan,
			logic [PERIOD_W-1:0] period);
		timer_report_t rep;
		logic [PERIOD_W:0] next;
		logic [IDX_W-1:0] idx;
		rep = '0;
		idx = chan[IDX_W-1:0];
		if (func == FUNC_TICK) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (chan_running[i]) begin
					next = {1'b0, chan_count[i]} + {{PERIOD_W{1'b0}}, 1'b1};
					if (next >= {1'b0, chan_period[i]}) begin
						chan_count[i] = '0;
						if (i < MASK_W) rep.fired_mask[i] = 1'b1;
						if (chan_oneshot[i]) chan_running[i] = 1'b0;
					end else begin
						chan_count[i] = next[PERIOD_W-1:0];
					end
				end
			end
		end else if (chan >= CHANNELS) begin
			rep.status = 1'b1;
		end else if (func == FUNC_STOP) begin
			chan_running[idx] = 1'b0;
		end else if (period == '0) begin
			rep.status = 1'b1;
		end else begin
			chan_count[idx] = '0;
			chan_period[idx] = period;
			chan_oneshot[idx] = (func == FUNC_START_ONE);
			chan_running[idx] = 1'b1;
		end
		return rep;
	endfunction

	task automatic send_request(mctt_func_t func, logic [CHAN_ID_W-1:0] chan,
			logic [PERIOD_W-1:0] period);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, period, chan, func};
		do @(posedge clk); while (!s_tready);
		reports_due.push_back(timer_bank_step(func, chan, period));
	endtask

	// mostly ticks and short periods on real channels so channels expire often
	task automatic send_random_request();
		int sel;
		mctt_func_t func;
		logic [CHAN_ID_W-1:0] chan;
		logic [PERIOD_W-1:0] period;
		sel = $urandom_range(99);
		if ($urandom_range(9) == 0) chan = 4'($urandom_range(15, CHANNELS));
		else chan = 4'($urandom_range(CHANNELS - 1));
		case ($urandom_range(9))
			0: period = '0;
			1: period = 16'($urandom);
			default: period = 16'($urandom_range(12, 1));
		endcase
		if (sel < 50) func = FUNC_TICK;
		else if (sel < 70) func = FUNC_START_PER;
		else if (sel < 85) func = FUNC_START_ONE;
		else func = FUNC_STOP;
		send_request(func, chan, period);
	endtask

	task automatic check_report(logic [OUT_W-1:0] word);
		timer_report_t due;
		if (reports_due.size() == 0) begin
			$error("unexpected result %h", word);
			mismatches++;
		end else begin
			due = reports_due.pop_front();
			if (word[0] !== due.status) begin
				$error("status expected %0d actual %0d", due.status, word[0]);
				mismatches++;
			end
			if (word[MASK_W:1] !== due.fired_mask) begin
				$error("fired_mask expected %h actual %h", due.fired_mask, word[MASK_W:1]);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_report(m_tdata);
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic test_directed();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_request(FUNC_TICK, 4'd15, 16'hffff);
		send_request(FUNC_START_PER, 4'd0, 16'd1);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_START_ONE, 4'd7, 16'd1);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_START_PER, 4'd8, 16'd5);
		send_request(FUNC_START_ONE, 4'd15, 16'hffff);
		send_request(FUNC_START_PER, 4'd2, 16'd0);
		send_request(FUNC_STOP, 4'd15, 16'd0);
		send_request(FUNC_STOP, 4'd3, 16'd0);
		send_request(FUNC_START_PER, 4'd3, 16'hffff);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_START_ONE, 4'd3, 16'd2);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_START_PER, 4'd5, 16'd3);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_STOP, 4'd5, 16'd0);
		send_request(FUNC_START_PER, 4'd5, 16'd2);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_TICK, 4'd0, 16'd0);
		send_request(FUNC_STOP, 4'd0, 16'd0);
		send_request(FUNC_TICK, 4'd0, 16'd0);
	endtask

	task automatic test_random(int count, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count) send_random_request();
	endtask

	// receiver held off while requests keep coming, so the input side must stall
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		fork
			begin
				@(negedge clk);
				rx_hold = 1'b1;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end
		join_none
		repeat (40) send_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(395, 0, 0);
		test_random(395, 77, 0);
		test_random(395, 0, 77);
		test_random(395, 35, 35);
		test_backpressure();
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> multi_channel_tick_timer.f
+incdir+src
src/mctt_pkg.sv
src/mctt_chan.sv
src/multi_channel_tick_timer.sv
tb/multi_channel_tick_timer_tb.sv
